@@ rtl/xsf_pkg.sv @@
// shared types and constants for the xor sprite framebuffer
package xsf_pkg;

	localparam int SCREEN_WIDTH_DEF  = 64;
	localparam int SCREEN_HEIGHT_DEF = 32;
	localparam int SPRITE_W          = 8;
	localparam int SUM_W             = 9;

	localparam logic [1:0] OP_DRAW  = 2'd0;
	localparam logic [1:0] OP_CLEAR = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;

	typedef struct packed {
		logic [1:0]          op;
		logic [7:0]          x_pos;
		logic [7:0]          y_pos;
		logic [SPRITE_W-1:0] row_bits;
		logic                last_row;
	} req_t;

	typedef struct packed {
		logic collision;
		logic pixel_value;
	} res_t;

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_MOD  = 6'b000010,
		S_RD   = 6'b000100,
		S_LOAD = 6'b001000,
		S_DRAW = 6'b010000,
		S_WB   = 6'b100000
	} state_t;

endpackage

@@ rtl/xor_sprite_framebuffer.sv @@
// one-bit framebuffer with xor sprite row drawing, collision flag, clear and pixel read
// draw: the 9-step bit-serial wrap of x and y, a row memory read, the row load, one pixel a cycle, write-back
// read: the wrap, the row memory read and the row load; clear or no-op finish straight from idle
// busy drops with done; a new request is taken only once the last one is finished
// the receiver cannot stall; each result is shown for exactly one cycle
// reset (and clear) zero the picture at once through per-line valid bits; no clearing pass
module xor_sprite_framebuffer #(
	parameter int SCREEN_WIDTH  = xsf_pkg::SCREEN_WIDTH_DEF,
	parameter int SCREEN_HEIGHT = xsf_pkg::SCREEN_HEIGHT_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  xsf_pkg::req_t req,
	output logic          busy,
	output logic          done,
	output xsf_pkg::res_t res
);
	import xsf_pkg::*;

	localparam int XW     = $clog2(SCREEN_WIDTH);
	localparam int YW     = $clog2(SCREEN_HEIGHT);
	localparam int STEP_W = $clog2(SUM_W);
	localparam int PIX_W  = $clog2(SPRITE_W);
	localparam logic [XW:0]       W_C       = (XW+1)'(SCREEN_WIDTH);
	localparam logic [YW:0]       H_C       = (YW+1)'(SCREEN_HEIGHT);
	localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(SUM_W - 1);
	localparam logic [PIX_W-1:0]  PIX_LAST  = PIX_W'(SPRITE_W - 1);

	state_t                  state_q;
	logic [1:0]              op_q;
	logic                    last_q;
	logic [SUM_W-1:0]        shx_q;
	logic [SUM_W-1:0]        shy_q;
	logic [XW-1:0]           rx_q;
	logic [YW-1:0]           ry_q;
	logic [STEP_W-1:0]       step_q;
	logic [XW-1:0]           col_q;
	logic [SPRITE_W-1:0]     bits_q;
	logic [PIX_W-1:0]        pix_q;
	logic [SCREEN_WIDTH-1:0] row_q;
	logic [SCREEN_WIDTH-1:0] rdata_q;
	logic [SCREEN_HEIGHT-1:0] valid_q;
	logic [7:0]              row_cnt_q;
	logic                    coll_q;
	logic                    done_q;
	res_t                    res_q;

	logic [SCREEN_WIDTH-1:0] mem_q [SCREEN_HEIGHT];

	logic             accept;
	logic [SUM_W-1:0] y_sum;
	logic [XW:0]      tx;
	logic [YW:0]      ty;
	logic [XW-1:0]    rx_nxt;
	logic [YW-1:0]    ry_nxt;
	logic [XW:0]      col_inc;
	logic [XW-1:0]    col_nxt;
	logic             old_px;
	logic             spr_bit;

	assign busy   = (state_q != S_IDLE);
	assign accept = start & ~busy;
	assign done   = done_q;
	assign res    = res_q;

	// draw lands on y plus the sprite row count, read on y itself
	assign y_sum = {1'b0, req.y_pos}
		+ ((req.op == OP_DRAW) ? {1'b0, row_cnt_q} : SUM_W'(0));

	// restoring remainder, one bit per cycle, msb first
	assign tx     = {rx_q, shx_q[SUM_W-1]};
	assign ty     = {ry_q, shy_q[SUM_W-1]};
	assign rx_nxt = (tx >= W_C) ? XW'(tx - W_C) : tx[XW-1:0];
	assign ry_nxt = (ty >= H_C) ? YW'(ty - H_C) : ty[YW-1:0];

	assign col_inc = {1'b0, col_q} + (XW+1)'(1);
	assign col_nxt = (col_inc == W_C) ? XW'(0) : col_inc[XW-1:0];
	assign old_px  = row_q[col_q];
	assign spr_bit = bits_q[SPRITE_W-1];

	// line memory, registered read
	always_ff @(posedge clk) begin
		if (state_q == S_WB) begin
			mem_q[ry_q] <= row_q;
		end
		rdata_q <= mem_q[ry_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			op_q      <= OP_DRAW;
			last_q    <= 1'b0;
			shx_q     <= '0;
			shy_q     <= '0;
			rx_q      <= '0;
			ry_q      <= '0;
			step_q    <= '0;
			col_q     <= '0;
			bits_q    <= '0;
			pix_q     <= '0;
			row_q     <= '0;
			valid_q   <= '0;
			row_cnt_q <= '0;
			coll_q    <= 1'b0;
			done_q    <= 1'b0;
			res_q     <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						op_q   <= req.op;
						last_q <= req.last_row;
						bits_q <= req.row_bits;
						shx_q  <= {1'b0, req.x_pos};
						shy_q  <= y_sum;
						rx_q   <= '0;
						ry_q   <= '0;
						step_q <= '0;
						case (req.op)
							OP_DRAW, OP_READ: begin
								state_q <= S_MOD;
							end
							OP_CLEAR: begin
								valid_q <= '0;
								done_q  <= 1'b1;
								res_q   <= '0;
							end
							default: begin
								done_q <= 1'b1;
								res_q  <= '0;
							end
						endcase
					end
				end
				S_MOD: begin
					rx_q   <= rx_nxt;
					ry_q   <= ry_nxt;
					shx_q  <= shx_q << 1;
					shy_q  <= shy_q << 1;
					step_q <= step_q + STEP_W'(1);
					if (step_q == STEP_LAST) begin
						state_q <= S_RD;
					end
				end
				S_RD: begin
					state_q <= S_LOAD;
				end
				S_LOAD: begin
					// a line never written since the last clear reads as all zero
					row_q <= valid_q[ry_q] ? rdata_q : '0;
					col_q <= rx_q;
					pix_q <= '0;
					if (op_q == OP_READ) begin
						done_q            <= 1'b1;
						res_q.collision   <= 1'b0;
						res_q.pixel_value <= valid_q[ry_q] & rdata_q[rx_q];
						state_q           <= S_IDLE;
					end else begin
						state_q <= S_DRAW;
					end
				end
				S_DRAW: begin
					row_q[col_q] <= old_px ^ spr_bit;
					coll_q       <= coll_q | (spr_bit & old_px);
					bits_q       <= bits_q << 1;
					col_q        <= col_nxt;
					pix_q        <= pix_q + PIX_W'(1);
					if (pix_q == PIX_LAST) begin
						state_q <= S_WB;
					end
				end
				S_WB: begin
					valid_q[ry_q]     <= 1'b1;
					done_q            <= 1'b1;
					res_q.collision   <= coll_q;
					res_q.pixel_value <= 1'b0;
					if (last_q) begin
						row_cnt_q <= '0;
						coll_q    <= 1'b0;
					end else begin
						row_cnt_q <= row_cnt_q + 8'd1;
					end
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// a clear request empties every line by the next edge
	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && req.op == OP_CLEAR) |=> (valid_q == '0))
		else $error("clear request left a line valid");

	// a lit pixel is only ever reported for a read request
	a_pixel_on_read: assert property (@(posedge clk) disable iff (!arst_n)
		(done && res.pixel_value) |-> (op_q == OP_READ))
		else $error("pixel value set on a non-read result");

	// the end of a sprite rewinds the row count and the gathered flag
	a_sprite_end: assert property (@(posedge clk) disable iff (!arst_n)
		(done && op_q == OP_DRAW && last_q) |-> (row_cnt_q == '0 && !coll_q))
		else $error("sprite state not cleared after last row");

	// write-back marks its line as holding data
	a_wb_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WB) |=> valid_q[ry_q])
		else $error("written line not marked valid");

	// a result only appears once the block is free again
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

endmodule
